[sv/sac_pkg.sv]
// Shared types, codes and helpers for the sunrise alarm controller.
`timescale 1ns / 1ps

package sac_pkg;

  localparam int unsigned LevelW   = 32;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned PctW     = 7;
  localparam int unsigned UnitW    = 26;  // widest value of a 32-bit word over 100
  localparam int unsigned CfgIdxW  = 3;

  // Reciprocal of 100 for a 32-bit dividend: exact as (x * Recip100) >> Div100Shift
  localparam logic [30:0] Recip100    = 31'h51EB851F;
  localparam int unsigned Div100Shift = 37;
  localparam int unsigned ProdW       = 63;

  localparam logic [LevelW-1:0]   FullScaleRst     = 32'd65535;
  localparam logic [LevelW-1:0]   AlarmPeakRst     = 32'hFFFF_FFFF;
  localparam logic [LevelW-1:0]   RampIncrementRst = 32'd1;
  localparam logic [TimeoutW-1:0] SoundTimeoutRst  = 16'd600;
  localparam logic [TimeoutW-1:0] LightTimeoutRst  = 16'd1800;
  localparam logic [TimeoutW-1:0] SnoozeSecondsRst = 16'd600;

  localparam logic [LevelW-1:0] Step60 = 32'd60;
  localparam logic [LevelW-1:0] Step45 = 32'd45;
  localparam logic [LevelW-1:0] Step37 = 32'd37;

  typedef enum logic [2:0] {
    MODE_OFF      = 3'd0,
    MODE_SNOOZED  = 3'd1,
    MODE_LIGHTS   = 3'd2,
    MODE_SOUND    = 3'd3,
    MODE_TIMEDOUT = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    REQ_TICK     = 3'd0,
    REQ_ALARM    = 3'd1,
    REQ_SNOOZE   = 3'd2,
    REQ_STOP     = 3'd3,
    REQ_BUTTON   = 3'd4,
    REQ_SET_LAMP = 3'd5,
    REQ_TIME     = 3'd6
  } req_e;

  typedef enum logic [2:0] {
    STEP_OFF  = 3'd0,
    STEP_FULL = 3'd1,
    STEP_60   = 3'd2,
    STEP_45   = 3'd3,
    STEP_37   = 3'd4
  } step_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FULL_SCALE     = 3'd0,
    CFG_ALARM_PEAK     = 3'd1,
    CFG_RAMP_INCREMENT = 3'd2,
    CFG_SOUND_TIMEOUT  = 3'd3,
    CFG_LIGHT_TIMEOUT  = 3'd4,
    CFG_SNOOZE_SECONDS = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [LevelW-1:0] lamp_drive;
    logic              sound_on;
    logic [2:0]        alarm_mode;
    logic              snooze_set;
    logic [TimeW-1:0]  snooze_until;
    logic              snooze_clear;
  } result_t;

  // Divide by 100 through the reciprocal product, no divider needed.
  function automatic logic [UnitW-1:0] div100(input logic [LevelW-1:0] x);
    logic [ProdW-1:0] prod;
    prod = ProdW'(x) * ProdW'(Recip100);
    return prod[ProdW-1:Div100Shift];
  endfunction

endpackage

[sv/sunrise_alarm_controller.sv]
// Top level of the sunrise alarm controller: event decode, alarm state and result buffering.
`timescale 1ns / 1ps

//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------------
//  in      | inbound   | in_valid_i / in_stall_o    | req_type, now_seconds, button_held, pct
//  out     | outbound  | out_valid_o / out_stall_i  | lamp_drive, sound_on, alarm_mode, snooze_*
//  cfg     | inbound   | cfg_we_i, cfg_idx_i        | cfg_wdata_i (16-bit registers take low half)
//
//  One event per cycle while the input is not stalled: each transfer updates the alarm state at
//  the same edge, which registers its result into the output register, or the skid stage if held.
//  The input stalls only while the skid stage holds a result, i.e. after the output
//  has been stalled with a second result already in flight.
//  Reset (asynchronous, active low) clears the alarm state, empties both result stages
//  and loads the register defaults; there is no clearing pass.
//  The multipliers on the event path take the stored scale unit times lamp percent or a step value;
//  full_scale over 100 is formed once, when full_scale is written or loaded at reset.

module sunrise_alarm_controller (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [sac_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [sac_pkg::LevelW-1:0]      cfg_wdata_i,
  // events
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [2:0]                      req_type_i,
  input  logic [sac_pkg::TimeW-1:0]       now_seconds_i,
  input  logic                            button_held_i,
  input  logic [sac_pkg::PctW-1:0]        lamp_percent_i,
  // results
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [sac_pkg::LevelW-1:0]      lamp_drive_o,
  output logic                            sound_on_o,
  output logic [2:0]                      alarm_mode_o,
  output logic                            snooze_set_o,
  output logic [sac_pkg::TimeW-1:0]       snooze_until_o,
  output logic                            snooze_clear_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [sac_pkg::LevelW-1:0]   full_scale_q;
  logic [sac_pkg::UnitW-1:0]    unit_q;          // full_scale / 100, kept alongside
  logic [sac_pkg::LevelW-1:0]   alarm_peak_q;
  logic [sac_pkg::LevelW-1:0]   ramp_inc_q;
  logic [sac_pkg::TimeoutW-1:0] sound_timeout_q;
  logic [sac_pkg::TimeoutW-1:0] light_timeout_q;
  logic [sac_pkg::TimeoutW-1:0] snooze_secs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q    <= sac_pkg::FullScaleRst;
      unit_q          <= sac_pkg::div100(sac_pkg::FullScaleRst);
      alarm_peak_q    <= sac_pkg::AlarmPeakRst;
      ramp_inc_q      <= sac_pkg::RampIncrementRst;
      sound_timeout_q <= sac_pkg::SoundTimeoutRst;
      light_timeout_q <= sac_pkg::LightTimeoutRst;
      snooze_secs_q   <= sac_pkg::SnoozeSecondsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sac_pkg::CFG_FULL_SCALE: begin
          full_scale_q <= cfg_wdata_i;
          unit_q       <= sac_pkg::div100(cfg_wdata_i);
        end
        sac_pkg::CFG_ALARM_PEAK:     alarm_peak_q    <= cfg_wdata_i;
        sac_pkg::CFG_RAMP_INCREMENT: ramp_inc_q      <= cfg_wdata_i;
        sac_pkg::CFG_SOUND_TIMEOUT:  sound_timeout_q <= cfg_wdata_i[sac_pkg::TimeoutW-1:0];
        sac_pkg::CFG_LIGHT_TIMEOUT:  light_timeout_q <= cfg_wdata_i[sac_pkg::TimeoutW-1:0];
        sac_pkg::CFG_SNOOZE_SECONDS: snooze_secs_q   <= cfg_wdata_i[sac_pkg::TimeoutW-1:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Alarm state
  // ---------------------------------------------------------------------------
  sac_pkg::mode_e             mode_q, mode_d;
  sac_pkg::step_e             step_q, step_d;
  logic [sac_pkg::LevelW-1:0] ramp_q, ramp_d;
  logic [sac_pkg::LevelW-1:0] lamp_q, lamp_d;
  logic                       sound_q, sound_d;
  logic [sac_pkg::TimeW-1:0]  start_q, start_d;

  logic                       pulse_set;
  logic                       pulse_clear;
  logic [sac_pkg::TimeW-1:0]  wake_time;
  logic [sac_pkg::TimeW-1:0]  elapsed;
  logic [sac_pkg::LevelW-1:0] unit_w;

  logic in_fire;
  sac_pkg::result_t res_new;

  assign unit_w = sac_pkg::LevelW'(unit_q);

  always_comb begin
    mode_d      = mode_q;
    step_d      = step_q;
    ramp_d      = ramp_q;
    lamp_d      = lamp_q;
    sound_d     = sound_q;
    start_d     = start_q;
    pulse_set   = 1'b0;
    pulse_clear = 1'b0;
    wake_time   = '0;

    unique case (sac_pkg::req_e'(req_type_i))
      sac_pkg::REQ_TICK: begin
        // advance the ramp while at or below the peak, in any active mode
        if (mode_q != sac_pkg::MODE_OFF && ramp_q <= alarm_peak_q) begin
          ramp_d = ramp_q + ramp_inc_q;
          lamp_d = ramp_d;
        end
      end
      sac_pkg::REQ_ALARM: begin
        if (mode_q == sac_pkg::MODE_OFF) begin
          mode_d = sac_pkg::MODE_LIGHTS;
          ramp_d = full_scale_q >> 4;
          lamp_d = ramp_d;
        end else if (mode_q == sac_pkg::MODE_SNOOZED) begin
          mode_d = sac_pkg::MODE_LIGHTS;
        end
      end
      sac_pkg::REQ_SNOOZE: begin
        if (mode_q == sac_pkg::MODE_OFF) begin
          lamp_d = '0;
          ramp_d = '0;
        end else begin
          pulse_set = 1'b1;
          wake_time = now_seconds_i + sac_pkg::TimeW'(snooze_secs_q);
          mode_d    = sac_pkg::MODE_SNOOZED;
        end
        sound_d = 1'b0;
      end
      sac_pkg::REQ_STOP: begin
        lamp_d      = '0;
        ramp_d      = '0;
        sound_d     = 1'b0;
        mode_d      = sac_pkg::MODE_OFF;
        pulse_clear = 1'b1;
      end
      sac_pkg::REQ_BUTTON: begin
        if (mode_q != sac_pkg::MODE_OFF) begin
          if (button_held_i) begin
            // long press: stop the alarm
            lamp_d      = '0;
            ramp_d      = '0;
            sound_d     = 1'b0;
            mode_d      = sac_pkg::MODE_OFF;
            pulse_clear = 1'b1;
          end else begin
            // short press: snooze
            pulse_set = 1'b1;
            wake_time = now_seconds_i + sac_pkg::TimeW'(snooze_secs_q);
            mode_d    = sac_pkg::MODE_SNOOZED;
            sound_d   = 1'b0;
          end
        end else if (button_held_i) begin
          // cycle the bedside lamp brightness
          case (step_q)
            sac_pkg::STEP_FULL: begin
              lamp_d = unit_w * sac_pkg::Step60;
              step_d = sac_pkg::STEP_60;
            end
            sac_pkg::STEP_60: begin
              lamp_d = unit_w * sac_pkg::Step45;
              step_d = sac_pkg::STEP_45;
            end
            sac_pkg::STEP_45: begin
              lamp_d = unit_w * sac_pkg::Step37;
              step_d = sac_pkg::STEP_37;
            end
            sac_pkg::STEP_37: begin
              lamp_d = '0;
              step_d = sac_pkg::STEP_OFF;
            end
            default: begin
              lamp_d = full_scale_q;
              step_d = sac_pkg::STEP_FULL;
            end
          endcase
        end
      end
      sac_pkg::REQ_SET_LAMP: begin
        // percent is not clipped; product wraps to the word width
        lamp_d = sac_pkg::LevelW'(lamp_percent_i) * unit_w;
      end
      default: ;  // time update or unused code: checks below only
    endcase

    // ramp has reached the peak: start the sound
    if (mode_d == sac_pkg::MODE_LIGHTS && ramp_d >= alarm_peak_q) begin
      sound_d = 1'b1;
      start_d = now_seconds_i;
      mode_d  = sac_pkg::MODE_SOUND;
    end

    elapsed = now_seconds_i - start_d;
    if (elapsed > sac_pkg::TimeW'(sound_timeout_q) && mode_d == sac_pkg::MODE_SOUND) begin
      sound_d = 1'b0;
      mode_d  = sac_pkg::MODE_TIMEDOUT;
    end else if (elapsed > sac_pkg::TimeW'(light_timeout_q)
                 && mode_d == sac_pkg::MODE_TIMEDOUT) begin
      lamp_d      = '0;
      ramp_d      = '0;
      sound_d     = 1'b0;
      mode_d      = sac_pkg::MODE_OFF;
      pulse_clear = 1'b1;
    end

    res_new.lamp_drive   = lamp_d;
    res_new.sound_on     = sound_d;
    res_new.alarm_mode   = mode_d;
    res_new.snooze_set   = pulse_set;
    res_new.snooze_until = wake_time;
    res_new.snooze_clear = pulse_clear;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= sac_pkg::MODE_OFF;
      step_q  <= sac_pkg::STEP_OFF;
      ramp_q  <= '0;
      lamp_q  <= '0;
      sound_q <= 1'b0;
      start_q <= '0;
    end else if (in_fire) begin
      mode_q  <= mode_d;
      step_q  <= step_d;
      ramp_q  <= ramp_d;
      lamp_q  <= lamp_d;
      sound_q <= sound_d;
      start_q <= start_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register with skid stage
  // ---------------------------------------------------------------------------
  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  sac_pkg::result_t out_q;
  sac_pkg::result_t skid_q;
  logic             out_fire;
  logic             load_out;
  logic             load_skid;

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i & ~skid_valid_q;
  assign out_fire   = out_valid_q & ~out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    load_out     = 1'b0;
    load_skid    = 1'b0;
    if (out_fire) begin
      out_valid_d = 1'b0;
    end
    if (skid_valid_q) begin
      // refill the output from the skid once the output transfer goes through
      if (out_fire) begin
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        load_out    = 1'b1;
        out_valid_d = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= res_new;
    end else if (skid_valid_q && out_fire) begin
      out_q <= skid_q;
    end
    if (load_skid) begin
      skid_q <= res_new;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign lamp_drive_o   = out_q.lamp_drive;
  assign sound_on_o     = out_q.sound_on;
  assign alarm_mode_o   = out_q.alarm_mode;
  assign snooze_set_o   = out_q.snooze_set;
  assign snooze_until_o = out_q.snooze_until;
  assign snooze_clear_o = out_q.snooze_clear;

endmodule
